>>> hdl/json_key_string_extractor_assert.svh
// Assertion macros for the port checker of the JSON key string extractor.
// Needs a clock named clock and a reset named reset in the scope where the macros are used.
`ifndef JSON_KEY_STRING_EXTRACTOR_ASSERT_SVH
`define JSON_KEY_STRING_EXTRACTOR_ASSERT_SVH

// A property that is checked only while the block is out of reset.
`define JKSE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("jkse assertion failed");

// A property that is also checked while reset is high.
`define JKSE_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("jkse assertion failed");

`endif

>>> hdl/jkse_pkg.sv
// Package of the JSON key string extractor: beat types, character codes and sizes.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package jkse_pkg;

   localparam int KEY_BYTES_DEFAULT = 16;
   localparam int KEY_REG_BITS      = 64;
   localparam int KEY_LEN_BITS      = 5;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 64;
   localparam int MAX_RESULTS       = 3;
   localparam int QUEUE_DEPTH       = 4;
   localparam int RAW_BITS          = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_LENGTH = 2'd2;

   localparam logic [KEY_LEN_BITS-1:0] KEY_LENGTH_RESET = 5'd1;
   localparam logic [RAW_BITS-1:0]     RAW_BYTES        = 3'd4;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   typedef struct packed {
      logic [7:0] doc_byte;
      logic       doc_end;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       is_status;
      logic       found;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [MAX_RESULTS-1:0]   items;
   } group_type;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_SKIP,
      PH_VALUE,
      PH_ESCAPE,
      PH_RAW,
      PH_DONE
   } phase_type;

endpackage

`default_nettype wire

>>> hdl/jkse_window_cell.sv
// One cell of the key search window: holds one recent byte and checks it against the key.
// Depends on jkse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jkse_window_cell #(
   parameter int MAX_KEY_BYTES = jkse_pkg::KEY_BYTES_DEFAULT,
   parameter int POSITION      = 0,
   localparam int KLW = $clog2(MAX_KEY_BYTES + 1),
   localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            shift,
   input  wire logic                            clear,
   input  wire logic [7:0]                      byte_in,
   input  wire logic                            valid_in,
   input  wire logic [MAX_KEY_BYTES-1:0][7:0]   key_chars,
   input  wire logic [KLW-1:0]                  key_len,
   output logic [7:0]                           byte_out,
   output logic                                 valid_out,
   output logic                                 hit
);
   import jkse_pkg::*;

   logic [7:0]     byte_ff;
   logic           valid_ff;
   logic [KLW-1:0] pos;
   logic [KLW-1:0] key_idx;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         byte_ff <= byte_in;
      end
   end

   // The byte this cell holds is key character key_len-1-POSITION, and the cell just past
   // the key must hold the opening quote.
   always_comb begin
      pos     = KLW'(POSITION);
      key_idx = key_len - pos - KLW'(1);
      if (pos < key_len) begin
         hit = valid_ff && (byte_ff == key_chars[key_idx[KIW-1:0]]);
      end else if (pos == key_len) begin
         hit = valid_ff && (byte_ff == CH_QUOTE);
      end else begin
         hit = 1'b1;
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

`default_nettype wire

>>> hdl/jkse_parser.sv
// Parse state machine of the extractor: skips to the value, decodes escapes, forms results.
// Depends on jkse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jkse_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire jkse_pkg::req_type   beat,
   input  wire logic                hit,
   output logic                     shift,
   output logic                     clear,
   output jkse_pkg::group_type      group
);
   import jkse_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [RAW_BITS-1:0] raw_ff, raw_in;
   logic [7:0]          b;
   logic                is_skip;
   logic [1:0]          n;
   logic                status_done;
   group_type           grp;

   function automatic rsp_type make_value(input logic [7:0] v);
      rsp_type r;
      r            = '0;
      r.value_byte = v;
      return r;
   endfunction

   function automatic rsp_type make_status(input logic f);
      rsp_type r;
      r           = '0;
      r.is_status = 1'b1;
      r.found     = f;
      return r;
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         CH_LOWER_N: v = CH_LF;
         CH_LOWER_T: v = CH_TAB;
         CH_LOWER_R: v = CH_CR;
         CH_LOWER_B: v = CH_BS;
         CH_LOWER_F: v = CH_FF;
         default:    v = c;
      endcase
      return v;
   endfunction

   assign b       = beat.doc_byte;
   assign is_skip = (b == CH_SPACE) || (b == CH_COLON) || (b == CH_TAB) ||
                    (b == CH_LF) || (b == CH_CR);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         raw_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         raw_ff   <= raw_in;
      end
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      raw_in   = raw_ff;
      case (phase_ff)
         PH_SEARCH: begin
            if (hit) begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (b == CH_QUOTE) begin
               phase_in = PH_VALUE;
            end else if (!is_skip) begin
               phase_in = PH_DONE;
            end
         end
         PH_VALUE: begin
            if (b == CH_QUOTE) begin
               phase_in = PH_DONE;
            end else if (b == CH_BACKSLASH) begin
               phase_in = PH_ESCAPE;
            end
         end
         PH_ESCAPE: begin
            if (b == CH_LOWER_U) begin
               phase_in = PH_RAW;
               raw_in   = RAW_BYTES;
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_RAW: begin
            if (raw_ff != '0) begin
               raw_in = raw_ff - RAW_BITS'(1);
            end
            if (raw_in == '0) begin
               phase_in = PH_VALUE;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_SEARCH;
         end
      endcase
      if (beat.doc_end) begin
         phase_in = PH_SEARCH;
         raw_in   = '0;
      end
   end

   // Results of the current byte.
   always_comb begin
      grp         = '0;
      n           = 2'd0;
      status_done = 1'b0;
      case (phase_ff)
         PH_SKIP: begin
            if (!is_skip && (b != CH_QUOTE)) begin
               grp.items[0] = make_status(1'b0);
               n            = 2'd1;
               status_done  = 1'b1;
            end
         end
         PH_VALUE: begin
            if (b == CH_QUOTE) begin
               grp.items[0] = make_status(1'b1);
               n            = 2'd1;
               status_done  = 1'b1;
            end else if (b != CH_BACKSLASH) begin
               grp.items[0] = make_value(b);
               n            = 2'd1;
            end
         end
         PH_ESCAPE: begin
            if (b == CH_LOWER_U) begin
               grp.items[0] = make_value(CH_BACKSLASH);
               grp.items[1] = make_value(CH_LOWER_U);
               n            = 2'd2;
            end else begin
               grp.items[0] = make_value(decode_escape(b));
               n            = 2'd1;
            end
         end
         PH_RAW: begin
            grp.items[0] = make_value(b);
            n            = 2'd1;
         end
         PH_DONE: begin
            status_done = 1'b1;
         end
         default: begin
            n = 2'd0;
         end
      endcase
      if (beat.doc_end && !status_done) begin
         grp.items[n] = make_status(1'b0);
         n            = n + 2'd1;
      end
      if (n != 2'd0) begin
         grp.items[n - 2'd1].run_last = 1'b1;
      end
      grp.count = fire ? n : 2'd0;
   end

   assign group = grp;
   assign shift = fire && (phase_ff == PH_SEARCH);
   assign clear = fire && beat.doc_end;

endmodule

`default_nettype wire

>>> hdl/jkse_result_queue.sv
// Result queue of the extractor: takes up to three results per byte, sends one per cycle while not stalled.
// Depends on jkse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jkse_result_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire jkse_pkg::group_type   group,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output jkse_pkg::rsp_type          rsp_payload,
   output logic                       room
);
   import jkse_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   rsp_type       mem [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = mem[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign room        = (count_ff <= CW'(QUEUE_DEPTH - MAX_RESULTS));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(group.count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CW'(group.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < group.count) begin
            mem[wr_ptr_ff + PW'(i)] <= group.items[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/json_key_string_extractor.sv
// Top level of the JSON key string extractor: key registers, search window, parser, queue.
// Depends on jkse_pkg, jkse_window_cell, jkse_parser and jkse_result_queue.
//
//   Port group    Direction  Beat contents                      Handshake
//   req_*         in         doc_byte, doc_end                  req_valid / req_stall
//   rsp_*         out        value_byte, is_status, found,      rsp_valid / rsp_stall
//                            run_last
//   csr_*         in         key low, key high, key length      csr_we, no wait
//
// One document byte is accepted per cycle as long as the result queue has room for three
// results. The queue sends one result per cycle, so a byte that makes two or three results
// holds the input back for a while even when the output side runs flat out. Such a
// byte is the u of a \u escape, or a last byte whose value beat is followed by the status.
// A result appears on rsp_* in the cycle after its byte is accepted when the queue is empty.
// Reset needs no clearing pass; the block accepts bytes right after it.
// A stall on the result side fills the queue and then stalls the input; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module json_key_string_extractor #(
   parameter int MAX_KEY_BYTES = jkse_pkg::KEY_BYTES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire jkse_pkg::req_type                    req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output jkse_pkg::rsp_type                         rsp_payload,
   input  wire logic                                 csr_we,
   input  wire logic [jkse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [jkse_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import jkse_pkg::*;

   localparam int KLW = $clog2(MAX_KEY_BYTES + 1);

   // Configuration registers. Writes take effect on the next byte.
   logic [KEY_REG_BITS-1:0] key_low_ff, key_low_in;
   logic [KEY_REG_BITS-1:0] key_high_ff, key_high_in;
   logic [KEY_LEN_BITS-1:0] key_length_ff, key_length_in;

   logic [2*KEY_REG_BITS-1:0]       key_all;
   logic [MAX_KEY_BYTES-1:0][7:0]   key_chars;
   logic [KLW-1:0]                  key_len;

   logic [7:0]           win_byte  [MAX_KEY_BYTES+1];
   logic                 win_valid [MAX_KEY_BYTES+1];
   logic [MAX_KEY_BYTES:0] cell_hit;

   logic      fire;
   logic      hit;
   logic      shift;
   logic      clear;
   logic      room;
   group_type group;

   always_comb begin
      key_low_in    = key_low_ff;
      key_high_in   = key_high_ff;
      key_length_in = key_length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW:    key_low_in    = csr_wdata[KEY_REG_BITS-1:0];
            CSR_KEY_HIGH:   key_high_in   = csr_wdata[KEY_REG_BITS-1:0];
            CSR_KEY_LENGTH: key_length_in = csr_wdata[KEY_LEN_BITS-1:0];
            default:        key_low_in    = key_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= KEY_LENGTH_RESET;
      end else begin
         key_low_ff    <= key_low_in;
         key_high_ff   <= key_high_in;
         key_length_ff <= key_length_in;
      end
   end

   // Character i of the key sits in bits 8i upward of the two words taken together. A length
   // above the window size counts as the window size; zero means the needle is two quotes.
   assign key_all   = {key_high_ff, key_low_ff};
   assign key_chars = key_all[8*MAX_KEY_BYTES-1:0];
   assign key_len   = (key_length_ff > KEY_LEN_BITS'(MAX_KEY_BYTES)) ?
                      KLW'(MAX_KEY_BYTES) : key_length_ff[KLW-1:0];

   // The search window is a row of cells, newest byte in cell zero. Each cell checks its own
   // byte against the key character that belongs at its place, and the current byte must be
   // the closing quote of the needle. The row only moves while the key is being searched.
   for (genvar j = 0; j <= MAX_KEY_BYTES; j++) begin : g_cell
      if (j == 0) begin : g_first
         jkse_window_cell #(
            .MAX_KEY_BYTES (MAX_KEY_BYTES),
            .POSITION      (j)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .clear     (clear),
            .byte_in   (req_payload.doc_byte),
            .valid_in  (1'b1),
            .key_chars (key_chars),
            .key_len   (key_len),
            .byte_out  (win_byte[j]),
            .valid_out (win_valid[j]),
            .hit       (cell_hit[j])
         );
      end else begin : g_next
         jkse_window_cell #(
            .MAX_KEY_BYTES (MAX_KEY_BYTES),
            .POSITION      (j)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .clear     (clear),
            .byte_in   (win_byte[j-1]),
            .valid_in  (win_valid[j-1]),
            .key_chars (key_chars),
            .key_len   (key_len),
            .byte_out  (win_byte[j]),
            .valid_out (win_valid[j]),
            .hit       (cell_hit[j])
         );
      end
   end

   assign hit = (req_payload.doc_byte == CH_QUOTE) && (&cell_hit);

   // The input is stalled only when the queue could not take a full group of results.
   assign req_stall = !room;
   assign fire      = req_valid && !req_stall;

   jkse_parser u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .beat  (req_payload),
      .hit   (hit),
      .shift (shift),
      .clear (clear),
      .group (group)
   );

   jkse_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .group       (group),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .room        (room)
   );

endmodule

`default_nettype wire

>>> hdl/jkse_checker.sv
// Port checker of the JSON key string extractor, bound to the top level.
// Depends on jkse_pkg and json_key_string_extractor_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "json_key_string_extractor_assert.svh"

module jkse_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire jkse_pkg::req_type                    req_payload,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire jkse_pkg::rsp_type                    rsp_payload,
   input  wire logic                                 csr_we,
   input  wire logic [jkse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [jkse_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import jkse_pkg::*;

   // Nothing is offered in the cycle after reset.
   `JKSE_ASSERT_RST(a_idle_after_reset, reset |=> !rsp_valid)

   // A stalled result beat holds.
   `JKSE_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // A status always closes the run of results of its byte.
   `JKSE_ASSERT(a_status_last, rsp_valid && rsp_payload.is_status |-> rsp_payload.run_last)

   // Found is only ever set on a status beat, and a status carries no byte.
   `JKSE_ASSERT(a_found_on_status, rsp_valid && rsp_payload.found |-> rsp_payload.is_status)
   `JKSE_ASSERT(a_status_no_byte, rsp_valid && rsp_payload.is_status |-> rsp_payload.value_byte == 8'h00)

endmodule

bind json_key_string_extractor jkse_checker u_checker (.*);

`default_nettype wire

>>> sim/json_key_string_extractor_checker.sv
// Result checker for the JSON key string extractor: watches both channels, predicts the
// decoded value and status beats, and compares them in order. Depends on jkse_pkg.
`timescale 1ns / 1ps

module json_key_string_extractor_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  jkse_pkg::req_type                     req_payload,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  jkse_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_we,
   input  logic [jkse_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [jkse_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output int                                    mismatch_count,
   output int                                    awaiting_count,
   output int                                    found_count,
   output int                                    missing_count
);

   import jkse_pkg::*;

   localparam int KEY_SPAN = KEY_BYTES_DEFAULT;
   localparam int WINDOW   = KEY_SPAN + 1;

   logic [KEY_REG_BITS-1:0] key_low;
   logic [KEY_REG_BITS-1:0] key_high;
   logic [KEY_LEN_BITS-1:0] key_len;

   phase_type               phase;
   logic [7:0]              history [0:WINDOW-1];
   int                      bytes_held;
   logic [RAW_BITS-1:0]     raw_left;

   rsp_type                 predicted_beats [$];

   function automatic logic [7:0] key_char(input int i);
      if (i < 8) begin
         return key_low[8*i +: 8];
      end
      return key_high[8*(i-8) +: 8];
   endfunction

   // True when the quote in cur closes '"' key '"' against the bytes already seen.
   function automatic logic key_closes(input logic [7:0] cur);
      int   klen;
      int   k;
      logic hit;
      klen = (key_len > KEY_SPAN) ? KEY_SPAN : int'(key_len);
      hit = (cur == CH_QUOTE) && (bytes_held >= klen + 1) && (history[klen] == CH_QUOTE);
      for (k = 1; k <= klen; k++) begin
         if (history[klen - k] != key_char(k - 1)) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   function automatic rsp_type make_beat(input logic [7:0] v, input logic st, input logic f);
      rsp_type beat;
      beat.value_byte = v;
      beat.is_status  = st;
      beat.found      = f;
      beat.run_last   = 1'b0;
      return beat;
   endfunction

   function automatic int field_differs(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic clear_document();
      int k;
      phase = PH_SEARCH;
      for (k = 0; k < WINDOW; k++) begin
         history[k] = 8'h00;
      end
      bytes_held = 0;
      raw_left   = '0;
   endtask

   // Works out the beats one document byte causes and queues them.
   task automatic decode_doc_byte(input req_type item);
      rsp_type    made [0:MAX_RESULTS-1];
      int         count;
      int         k;
      logic       closed;
      logic       hit;
      logic [7:0] b;
      logic [7:0] v;
      b      = item.doc_byte;
      count  = 0;
      closed = 1'b0;
      case (phase)
         PH_SEARCH: begin
            hit = key_closes(b);
            for (k = WINDOW - 1; k > 0; k--) begin
               history[k] = history[k-1];
            end
            history[0] = b;
            if (bytes_held < WINDOW) begin
               bytes_held++;
            end
            if (hit) begin
               phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (b == CH_QUOTE) begin
               phase = PH_VALUE;
            end else if (b != CH_SPACE && b != CH_COLON && b != CH_TAB &&
                         b != CH_LF && b != CH_CR) begin
               made[count] = make_beat(8'h00, 1'b1, 1'b0);
               count++;
               closed = 1'b1;
               phase  = PH_DONE;
            end
         end
         PH_VALUE: begin
            if (b == CH_QUOTE) begin
               made[count] = make_beat(8'h00, 1'b1, 1'b1);
               count++;
               closed = 1'b1;
               phase  = PH_DONE;
            end else if (b == CH_BACKSLASH) begin
               phase = PH_ESCAPE;
            end else begin
               made[count] = make_beat(b, 1'b0, 1'b0);
               count++;
            end
         end
         PH_ESCAPE: begin
            phase = PH_VALUE;
            if (b == CH_LOWER_U) begin
               made[count] = make_beat(CH_BACKSLASH, 1'b0, 1'b0);
               count++;
               made[count] = make_beat(CH_LOWER_U, 1'b0, 1'b0);
               count++;
               raw_left = RAW_BYTES;
               phase    = PH_RAW;
            end else begin
               case (b)
                  CH_LOWER_N: v = CH_LF;
                  CH_LOWER_T: v = CH_TAB;
                  CH_LOWER_R: v = CH_CR;
                  CH_LOWER_B: v = CH_BS;
                  CH_LOWER_F: v = CH_FF;
                  default:    v = b;
               endcase
               made[count] = make_beat(v, 1'b0, 1'b0);
               count++;
            end
         end
         PH_RAW: begin
            made[count] = make_beat(b, 1'b0, 1'b0);
            count++;
            if (raw_left != 0) begin
               raw_left--;
            end
            if (raw_left == 0) begin
               phase = PH_VALUE;
            end
         end
         default: begin
            closed = 1'b1;
         end
      endcase

      // The last byte always closes the document, with a not-found status if none came yet.
      if (item.doc_end) begin
         if (!closed) begin
            made[count] = make_beat(8'h00, 1'b1, 1'b0);
            count++;
         end
         clear_document();
      end
      if (count > 0) begin
         made[count-1].run_last = 1'b1;
      end
      for (k = 0; k < count; k++) begin
         predicted_beats.push_back(made[k]);
         if (made[k].is_status) begin
            if (made[k].found) begin
               found_count++;
            end else begin
               missing_count++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      int      wrong;
      if (reset) begin
         key_low        = '0;
         key_high       = '0;
         key_len        = KEY_LENGTH_RESET;
         mismatch_count = 0;
         found_count    = 0;
         missing_count  = 0;
         predicted_beats.delete();
         clear_document();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_LOW:    key_low  = csr_wdata;
               CSR_KEY_HIGH:   key_high = csr_wdata;
               CSR_KEY_LENGTH: key_len  = csr_wdata[KEY_LEN_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_beats.size() == 0) begin
               $display("%0t: result beat with none expected, got %0h", $time, rsp_payload);
               mismatch_count++;
            end else begin
               want  = predicted_beats.pop_front();
               wrong = field_differs("value_byte", want.value_byte, rsp_payload.value_byte)
                     + field_differs("is_status", 8'(want.is_status), 8'(rsp_payload.is_status))
                     + field_differs("found", 8'(want.found), 8'(rsp_payload.found))
                     + field_differs("run_last", 8'(want.run_last), 8'(rsp_payload.run_last));
               if (wrong != 0) begin
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_doc_byte(req_payload);
         end
      end
      awaiting_count <= predicted_beats.size();
   end

endmodule

>>> sim/json_key_string_extractor_tb.sv
// Top of the JSON key string extractor testbench: clock, reset, document stimulus, key
// settings and verdict. Depends on jkse_pkg, the block and json_key_string_extractor_checker.
`timescale 1ns / 1ps

module json_key_string_extractor_tb;

   import jkse_pkg::*;

   localparam int KEY_SPAN         = KEY_BYTES_DEFAULT;
   localparam int RANDOM_BYTES     = 450;
   localparam int DOCS_PER_KEY     = 2;
   localparam int KEY_SETTINGS     = 7;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TIMEOUT_NS       = 5_000_000;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // Shapes of generated documents: a complete key and string, a key followed by junk
   // instead of an opening quote, a complete one cut off at a random byte, and pure noise.
   typedef enum {DOC_GOOD, DOC_BAD_SKIP, DOC_CUT_SHORT, DOC_NO_KEY} doc_kind_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   req_type                       req_payload;
   logic                          rsp_valid;
   logic                          rsp_stall;
   rsp_type                       rsp_payload;
   logic                          csr_we;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_wdata;

   int                            mismatch_count;
   int                            awaiting_count;
   int                            found_count;
   int                            missing_count;

   // Idle rates in percent; the receiver's is handed over with a nonblocking write since
   // another process reads it.
   int                            sender_gap_pct;
   int                            receiver_gap_pct;
   logic                          hold_request;

   // The key as last written, so that documents can be built around it.
   logic [KEY_REG_BITS-1:0]       key_low_cfg;
   logic [KEY_REG_BITS-1:0]       key_high_cfg;
   logic [KEY_LEN_BITS-1:0]       key_len_cfg;

   logic [7:0]                    doc_bytes [$];
   int                            docs_sent;
   int                            bytes_sent;
   int                            settings_used;

   json_key_string_extractor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   json_key_string_extractor_checker checker_unit (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaiting_count (awaiting_count),
      .found_count    (found_count),
      .missing_count  (missing_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: a hung handshake or a result that never arrives ends here.
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   // Result side. It stalls at the current rate, except for one long hold-off, counted
   // here in cycles, while the sender keeps offering bytes. The block's result queue then
   // fills and it has to stall its input.
   initial begin : result_side
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            repeat (LONG_HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_gap_pct);
      end
   end

   // Offers one document byte and returns once it has been taken. Valid stays high after
   // the beat so that a following beat can go out in the very next cycle.
   task automatic send_beat(input logic [7:0] b, input logic last);
      req_type beat;
      beat.doc_byte = b;
      beat.doc_end  = last;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_doc();
      int i;
      for (i = 0; i < doc_bytes.size(); i++) begin
         send_beat(doc_bytes[i], i == doc_bytes.size() - 1);
      end
      docs_sent++;
      bytes_sent += doc_bytes.size();
   endtask

   // Registers may only change with the block idle. Bytes in the search phase give no
   // result, so the task waits further settling cycles once the last awaited result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input logic [KEY_REG_BITS-1:0] lo, input logic [KEY_REG_BITS-1:0] hi,
                           input logic [KEY_LEN_BITS-1:0] len);
      csr_we    <= 1'b1;
      csr_index <= CSR_KEY_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_KEY_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_KEY_LENGTH;
      csr_wdata <= CSR_DATA_BITS'(len);
      @(posedge clock);
      csr_we <= 1'b0;
      key_low_cfg  = lo;
      key_high_cfg = hi;
      key_len_cfg  = len;
      settings_used++;
   endtask

   function automatic logic [7:0] skip_char();
      case ($urandom_range(4))
         0:       return CH_SPACE;
         1:       return CH_COLON;
         2:       return CH_TAB;
         3:       return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   // Builds one document around the current key into doc_bytes. A good document is noise,
   // the quoted key, some separators, and a quoted string of plain bytes, escapes and
   // \u sequences whose four raw bytes may be anything, quotes included.
   task automatic compose_doc(input doc_kind_type kind, input int min_pieces);
      int         klen;
      int         i;
      int         cut;
      logic [7:0] c;
      doc_bytes.delete();
      if (kind == DOC_NO_KEY) begin
         repeat ($urandom_range(5, 15)) doc_bytes.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 5)) doc_bytes.push_back(8'($urandom_range(255)));
         doc_bytes.push_back(CH_QUOTE);
         klen = (key_len_cfg > KEY_SPAN) ? KEY_SPAN : int'(key_len_cfg);
         for (i = 0; i < klen; i++) begin
            if (i < 8) begin
               doc_bytes.push_back(key_low_cfg[8*i +: 8]);
            end else begin
               doc_bytes.push_back(key_high_cfg[8*(i-8) +: 8]);
            end
         end
         doc_bytes.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 3)) doc_bytes.push_back(skip_char());
         if (kind == DOC_BAD_SKIP) begin
            c = CH_QUOTE;
            while (c == CH_QUOTE || c == CH_SPACE || c == CH_COLON || c == CH_TAB ||
                   c == CH_LF || c == CH_CR) begin
               c = 8'($urandom_range(255));
            end
            doc_bytes.push_back(c);
            repeat ($urandom_range(0, 4)) doc_bytes.push_back(8'($urandom_range(255)));
         end else begin
            doc_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(min_pieces, min_pieces + 8)) begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4, 5: begin
                     c = CH_QUOTE;
                     while (c == CH_QUOTE || c == CH_BACKSLASH) begin
                        c = 8'($urandom_range(255));
                     end
                     doc_bytes.push_back(c);
                  end
                  6, 7: begin
                     doc_bytes.push_back(CH_BACKSLASH);
                     case ($urandom_range(8))
                        0:       doc_bytes.push_back(CH_LOWER_N);
                        1:       doc_bytes.push_back(CH_LOWER_T);
                        2:       doc_bytes.push_back(CH_LOWER_R);
                        3:       doc_bytes.push_back(CH_LOWER_B);
                        4:       doc_bytes.push_back(CH_LOWER_F);
                        5:       doc_bytes.push_back(CH_SLASH);
                        6:       doc_bytes.push_back(CH_BACKSLASH);
                        7:       doc_bytes.push_back(CH_QUOTE);
                        default: doc_bytes.push_back(8'($urandom_range(255)));
                     endcase
                  end
                  default: begin
                     doc_bytes.push_back(CH_BACKSLASH);
                     doc_bytes.push_back(CH_LOWER_U);
                     repeat (4) doc_bytes.push_back(8'($urandom_range(255)));
                  end
               endcase
            end
            doc_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3)) doc_bytes.push_back(8'($urandom_range(255)));
            // A document cut short may end anywhere: in the key, the separators, an
            // escape or the middle of a \u sequence.
            if (kind == DOC_CUT_SHORT) begin
               cut = $urandom_range(1, doc_bytes.size() - 1);
               while (doc_bytes.size() > cut) begin
                  void'(doc_bytes.pop_back());
               end
            end
         end
      end
   endtask

   initial begin : stimulus
      int           random_bytes;
      int           docs_since_key;
      int           setting;
      int           roll;
      bit           hold_armed;
      doc_kind_type kind;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_KEY_LOW;
      csr_wdata        = '0;
      hold_request     = 1'b0;
      sender_gap_pct   = 14;
      receiver_gap_pct = 86;
      key_low_cfg      = '0;
      key_high_cfg     = '0;
      key_len_cfg      = KEY_LENGTH_RESET;
      docs_sent        = 0;
      bytes_sent       = 0;
      settings_used    = 0;
      random_bytes     = 0;
      docs_since_key   = DOCS_PER_KEY;
      setting          = 0;
      hold_armed       = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed documents under the reset key, a single NUL character. First a value
      // with the largest byte and a newline escape, closed on the document's last byte.
      doc_bytes = '{CH_QUOTE, 8'h00, CH_QUOTE, CH_COLON, CH_QUOTE, 8'hFF, CH_BACKSLASH,
                    CH_LOWER_N, CH_QUOTE};
      send_doc();
      // A \u sequence that the end of the document cuts short is not found.
      doc_bytes = '{CH_QUOTE, 8'h00, CH_QUOTE, CH_QUOTE, CH_BACKSLASH, CH_LOWER_U,
                    8'h31, 8'h32, 8'h33};
      send_doc();
      // Junk where the opening quote belongs fails at once; later bytes stay silent.
      doc_bytes = '{CH_QUOTE, 8'h00, CH_QUOTE, 8'h78, 8'h79};
      send_doc();
      // A document of one byte.
      doc_bytes = '{8'hFF};
      send_doc();

      // Random documents. The key changes every few documents, walking through empty,
      // single, full and oversized lengths and all-zero and all-one key bits.
      while (random_bytes < RANDOM_BYTES) begin
         if (docs_since_key == DOCS_PER_KEY) begin
            drain();
            case (setting % KEY_SETTINGS)
               0: load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
               1: load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
               2: load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
               3: load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd1);
               4: load_key({$urandom, $urandom}, {$urandom, $urandom},
                           KEY_LEN_BITS'($urandom_range(2, 15)));
               5: load_key('1, '1, 5'd8);
               default: load_key('0, '0, 5'd5);
            endcase
            setting++;
            docs_since_key = 0;
         end

         // A slow receiver first, then a slow sender, then both at full rate.
         if (random_bytes < RANDOM_BYTES / 3) begin
            sender_gap_pct   = 14;
            receiver_gap_pct <= 86;
         end else if (random_bytes < 2 * RANDOM_BYTES / 3) begin
            sender_gap_pct   = 86;
            receiver_gap_pct <= 14;
         end else begin
            sender_gap_pct   = 0;
            receiver_gap_pct <= 0;
         end

         if (random_bytes >= 2 * RANDOM_BYTES / 3 && !hold_armed) begin
            // A long string rides through the receiver's long hold-off.
            hold_armed = 1'b1;
            hold_request <= 1'b1;
            compose_doc(DOC_GOOD, 8);
         end else begin
            roll = $urandom_range(99);
            if (roll < 65) begin
               kind = DOC_GOOD;
            end else if (roll < 77) begin
               kind = DOC_BAD_SKIP;
            end else if (roll < 92) begin
               kind = DOC_CUT_SHORT;
            end else begin
               kind = DOC_NO_KEY;
            end
            compose_doc(kind, 0);
         end
         send_doc();
         random_bytes += doc_bytes.size();
         docs_since_key++;
      end

      drain();
      $display("Sent %0d document bytes in %0d documents under %0d key settings, through",
               bytes_sent, docs_sent, settings_used);
      $display("idle, stalled and full-rate phases: %0d strings found, %0d not found.",
               found_count, missing_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
